/* hdl/dhfk_pkg.sv */
package dhfk_pkg;

    localparam int MAX_LINKS = 7;
    localparam int FIFO_DEPTH = 2;

    localparam logic [2:0] REG_LINK_COUNT = 3'd0;

    localparam logic signed [33:0] PI_Q28 = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28 = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [33:0] OCT1_Q28 = 34'sd210828714;
    localparam logic signed [33:0] OCT3_Q28 = 34'sd632486142;

    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
    localparam logic signed [31:0] INV3F = 32'sd178956971;
    localparam logic signed [31:0] INV5F = 32'sd8947849;
    localparam logic signed [31:0] INV7F = 32'sd213044;
    localparam logic signed [31:0] INV2F = 32'sd536870912;
    localparam logic signed [31:0] INV4F = 32'sd44739243;
    localparam logic signed [31:0] INV6F = 32'sd1491308;
    localparam logic signed [31:0] INV8F = 32'sd26631;
    localparam logic signed [31:0] POSE_ONE = 32'sd65536;

    typedef struct packed {
        logic signed [15:0] twist;
        logic signed [15:0] length;
        logic signed [15:0] offset;
        logic signed [16:0] angle;
        logic               last;
    } link_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FOLD,
        ST_POLY,
        ST_BUILD,
        ST_UPDATE,
        ST_COMMIT
    } back_state_t;

    typedef enum logic [1:0] {
        QD_ZERO,
        QD_POS1,
        QD_NEG1,
        QD_HALF
    } quad_t;

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                        input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

/* hdl/dhfk_fifo.sv */
module dhfk_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  dhfk_pkg::link_item_t wr_data,
    output logic                 full,
    input  logic                 rd_en,
    output logic                 rd_valid,
    output dhfk_pkg::link_item_t rd_data
);

    dhfk_pkg::link_item_t mem [0:dhfk_pkg::FIFO_DEPTH-1];
    logic [$clog2(dhfk_pkg::FIFO_DEPTH)-1:0] wr_ptr_reg;
    logic [$clog2(dhfk_pkg::FIFO_DEPTH)-1:0] rd_ptr_reg;
    logic [$clog2(dhfk_pkg::FIFO_DEPTH):0]   count_reg;
    logic [$clog2(dhfk_pkg::FIFO_DEPTH):0]   count_next;

    assign full = (count_reg == ($clog2(dhfk_pkg::FIFO_DEPTH)+1)'(dhfk_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/dhfk_front.sv */
module dhfk_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic signed [15:0]   joint_angle,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 q_full,
    output logic                 q_wr,
    output dhfk_pkg::link_item_t q_data
);

    logic [2:0]  link_count_reg;
    logic [63:0] link_params_reg [0:dhfk_pkg::MAX_LINKS-1];
    logic [2:0]  link_index_reg;
    logic [2:0]  count_eff;
    logic [63:0] prm;
    logic        is_last;

    assign q_wr = push && !q_full;
    assign count_eff = (link_count_reg == 3'd0) ? 3'd1 : link_count_reg;
    assign prm = link_params_reg[link_index_reg];
    assign is_last = ({1'b0, link_index_reg} + 4'd1) >= {1'b0, count_eff};

    always_comb
    begin
        q_data.twist = prm[15:0];
        q_data.length = prm[31:16];
        q_data.offset = prm[47:32];
        q_data.angle = {joint_angle[15], joint_angle} + {prm[63], prm[63:48]};
        q_data.last = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_count_reg <= 3'd6;
            link_index_reg <= '0;
            for (int i = 0; i < dhfk_pkg::MAX_LINKS; i++)
                link_params_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == dhfk_pkg::REG_LINK_COUNT)
                    link_count_reg <= cfg_data[2:0];
                else
                    link_params_reg[cfg_index - 3'd1] <= cfg_data;
            end
            if (q_wr)
                link_index_reg <= is_last ? 3'd0 : link_index_reg + 3'd1;
        end
    end

endmodule

/* hdl/dhfk_back.sv */
module dhfk_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fifo_valid,
    input  dhfk_pkg::link_item_t fifo_data,
    output logic                 fifo_pop,
    input  logic                 pop,
    output logic                 out_valid,
    output logic signed [31:0]   out_pose [0:11]
);

    dhfk_pkg::back_state_t state_reg, state_next;
    dhfk_pkg::link_item_t  item_reg;
    dhfk_pkg::quad_t       quad_reg;
    dhfk_pkg::quad_t       quad_c;
    logic                  phase_reg;
    logic signed [33:0]    t_reg;
    logic signed [31:0]    x_reg, x2_reg, p_reg, s_reg;
    logic signed [31:0]    sa_reg, ca_reg, sq_reg, cq_reg;
    logic signed [31:0]    rot_reg [0:2][0:2];
    logic signed [31:0]    tr_reg [0:2];
    logic signed [31:0]    pose_reg [0:11];
    logic signed [31:0]    nxt_reg [0:11];
    logic signed [63:0]    prod_reg, acc_reg;
    logic signed [31:0]    mul_a, mul_b;
    logic [3:0]            op_reg;
    logic                  sub_reg;
    logic [3:0]            oi_reg;
    logic [1:0]            k_reg;
    logic                  out_valid_reg;
    logic signed [31:0]    out_reg [0:11];
    logic signed [33:0]    fold_c;
    logic signed [63:0]    r30_full, r26_full;
    logic signed [31:0]    r30, c_fin, sn_c, cs_c;
    logic signed [63:0]    fin;
    logic [1:0]            kk, jj;

    assign out_valid = out_valid_reg;
    assign out_pose = out_reg;
    assign r30_full = dhfk_pkg::round_shift(prod_reg, 30);
    assign r26_full = dhfk_pkg::round_shift(prod_reg, 26);
    assign r30 = r30_full[31:0];
    assign c_fin = dhfk_pkg::Q30_ONE + r30;
    assign fin = acc_reg + prod_reg;
    assign kk = (k_reg == 2'd3) ? 2'd0 : k_reg;
    assign jj = (oi_reg[1:0] == 2'd3) ? 2'd0 : oi_reg[1:0];

    always_comb
    begin
        if (t_reg > dhfk_pkg::OCT3_Q28)
        begin
            quad_c = dhfk_pkg::QD_HALF;
            fold_c = t_reg - (dhfk_pkg::HALF_PI_Q28 <<< 1);
        end
        else if (t_reg > dhfk_pkg::OCT1_Q28)
        begin
            quad_c = dhfk_pkg::QD_POS1;
            fold_c = t_reg - dhfk_pkg::HALF_PI_Q28;
        end
        else if (t_reg < -dhfk_pkg::OCT3_Q28)
        begin
            quad_c = dhfk_pkg::QD_HALF;
            fold_c = t_reg + (dhfk_pkg::HALF_PI_Q28 <<< 1);
        end
        else if (t_reg < -dhfk_pkg::OCT1_Q28)
        begin
            quad_c = dhfk_pkg::QD_NEG1;
            fold_c = t_reg + dhfk_pkg::HALF_PI_Q28;
        end
        else
        begin
            quad_c = dhfk_pkg::QD_ZERO;
            fold_c = t_reg;
        end
    end

    always_comb
    begin
        case (quad_reg)
            dhfk_pkg::QD_ZERO: begin sn_c = s_reg;  cs_c = c_fin;  end
            dhfk_pkg::QD_POS1: begin sn_c = c_fin;  cs_c = -s_reg; end
            dhfk_pkg::QD_NEG1: begin sn_c = -c_fin; cs_c = s_reg;  end
            default:           begin sn_c = -s_reg; cs_c = -c_fin; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        fifo_pop = 1'b0;
        mul_a = x2_reg;
        mul_b = p_reg;
        case (state_reg)
            dhfk_pkg::ST_IDLE:
            begin
                if (fifo_valid)
                begin
                    fifo_pop = 1'b1;
                    state_next = dhfk_pkg::ST_WRAP;
                end
            end
            dhfk_pkg::ST_WRAP:
            begin
                if (t_reg <= dhfk_pkg::PI_Q28 && t_reg > -dhfk_pkg::PI_Q28)
                    state_next = dhfk_pkg::ST_FOLD;
            end
            dhfk_pkg::ST_FOLD:
                state_next = dhfk_pkg::ST_POLY;
            dhfk_pkg::ST_POLY:
            begin
                case (op_reg)
                    4'd0: begin mul_a = x_reg; mul_b = x_reg; end
                    4'd1: mul_b = -dhfk_pkg::INV7F;
                    4'd4: mul_a = x_reg;
                    4'd5: mul_b = dhfk_pkg::INV8F;
                    default: ;
                endcase
                if (sub_reg && op_reg == 4'd8)
                    state_next = phase_reg ? dhfk_pkg::ST_BUILD : dhfk_pkg::ST_WRAP;
            end
            dhfk_pkg::ST_BUILD:
            begin
                case (op_reg)
                    4'd0: begin mul_a = sq_reg; mul_b = ca_reg; end
                    4'd1: begin mul_a = cq_reg; mul_b = ca_reg; end
                    4'd2: begin mul_a = sq_reg; mul_b = sa_reg; end
                    4'd3: begin mul_a = cq_reg; mul_b = sa_reg; end
                    4'd4: begin mul_a = sa_reg; mul_b = 32'(item_reg.offset); end
                    default: begin mul_a = ca_reg; mul_b = 32'(item_reg.offset); end
                endcase
                if (sub_reg && op_reg == 4'd5)
                    state_next = dhfk_pkg::ST_UPDATE;
            end
            dhfk_pkg::ST_UPDATE:
            begin
                mul_a = pose_reg[{oi_reg[3:2], k_reg}];
                mul_b = (oi_reg[1:0] == 2'd3) ? tr_reg[kk] : rot_reg[kk][jj];
                if (k_reg == 2'd3 && oi_reg == 4'd11)
                    state_next = dhfk_pkg::ST_COMMIT;
            end
            dhfk_pkg::ST_COMMIT:
            begin
                if (!item_reg.last || !out_valid_reg)
                    state_next = dhfk_pkg::ST_IDLE;
            end
            default:
                state_next = dhfk_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhfk_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 12; i++)
                pose_reg[i] <= (i % 5 == 0 && i < 11) ? dhfk_pkg::POSE_ONE : '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dhfk_pkg::ST_COMMIT && item_reg.last && !out_valid_reg)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (state_reg == dhfk_pkg::ST_COMMIT && state_next == dhfk_pkg::ST_IDLE)
            begin
                for (int i = 0; i < 12; i++)
                begin
                    if (item_reg.last)
                        pose_reg[i] <= (i % 5 == 0 && i < 11) ? dhfk_pkg::POSE_ONE : '0;
                    else
                        pose_reg[i] <= nxt_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            dhfk_pkg::ST_IDLE:
            begin
                item_reg <= fifo_data;
                phase_reg <= 1'b0;
                t_reg <= {{2{fifo_data.twist[15]}}, fifo_data.twist, 16'b0};
            end
            dhfk_pkg::ST_WRAP:
            begin
                if (t_reg > dhfk_pkg::PI_Q28)
                    t_reg <= t_reg - dhfk_pkg::TWO_PI_Q28;
                else if (t_reg <= -dhfk_pkg::PI_Q28)
                    t_reg <= t_reg + dhfk_pkg::TWO_PI_Q28;
            end
            dhfk_pkg::ST_FOLD:
            begin
                quad_reg <= quad_c;
                x_reg <= 32'(fold_c <<< 2);
                op_reg <= '0;
                sub_reg <= 1'b0;
            end
            dhfk_pkg::ST_POLY:
            begin
                sub_reg <= !sub_reg;
                if (sub_reg)
                begin
                    op_reg <= op_reg + 4'd1;
                    case (op_reg)
                        4'd0: x2_reg <= r30;
                        4'd1: p_reg <= dhfk_pkg::INV5F + r30;
                        4'd2: p_reg <= -dhfk_pkg::INV3F + r30;
                        4'd3: p_reg <= dhfk_pkg::Q30_ONE + r30;
                        4'd4: s_reg <= r30;
                        4'd5: p_reg <= -dhfk_pkg::INV6F + r30;
                        4'd6: p_reg <= dhfk_pkg::INV4F + r30;
                        4'd7: p_reg <= -dhfk_pkg::INV2F + r30;
                        default:
                        begin
                            op_reg <= '0;
                            if (phase_reg)
                            begin
                                sq_reg <= sn_c;
                                cq_reg <= cs_c;
                            end
                            else
                            begin
                                sa_reg <= sn_c;
                                ca_reg <= cs_c;
                                phase_reg <= 1'b1;
                                t_reg <= {item_reg.angle[16], item_reg.angle, 16'b0};
                            end
                        end
                    endcase
                end
            end
            dhfk_pkg::ST_BUILD:
            begin
                sub_reg <= !sub_reg;
                if (sub_reg)
                begin
                    op_reg <= op_reg + 4'd1;
                    case (op_reg)
                        4'd0: rot_reg[1][0] <= r30;
                        4'd1: rot_reg[1][1] <= r30;
                        4'd2: rot_reg[2][0] <= r30;
                        4'd3: rot_reg[2][1] <= r30;
                        4'd4: tr_reg[1] <= -(r26_full[31:0]);
                        default:
                        begin
                            tr_reg[2] <= r26_full[31:0];
                            tr_reg[0] <= 32'(item_reg.length) <<< 4;
                            rot_reg[0][0] <= cq_reg;
                            rot_reg[0][1] <= -sq_reg;
                            rot_reg[0][2] <= '0;
                            rot_reg[1][2] <= -sa_reg;
                            rot_reg[2][2] <= ca_reg;
                            oi_reg <= '0;
                            k_reg <= '0;
                        end
                    endcase
                end
            end
            dhfk_pkg::ST_UPDATE:
            begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd0)
                    acc_reg <= (oi_reg[1:0] == 2'd3)
                        ? (64'(pose_reg[{oi_reg[3:2], 2'd3}]) <<< 16) : '0;
                else if (k_reg != 2'd3)
                    acc_reg <= fin;
                else
                begin
                    nxt_reg[oi_reg] <= (oi_reg[1:0] == 2'd3)
                        ? dhfk_pkg::sat32(dhfk_pkg::round_shift(fin, 16))
                        : dhfk_pkg::sat32(dhfk_pkg::round_shift(fin, 30));
                    oi_reg <= oi_reg + 4'd1;
                end
            end
            dhfk_pkg::ST_COMMIT:
            begin
                if (item_reg.last && !out_valid_reg)
                    out_reg <= nxt_reg;
            end
            default: ;
        endcase
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dhfk_pkg::ST_COMMIT && item_reg.last && out_valid_reg && !pop)
        |=> state_reg == dhfk_pkg::ST_COMMIT)
        else $error("finished pose overwrote a waiting result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> (state_reg == dhfk_pkg::ST_IDLE && fifo_valid))
        else $error("queue read outside idle");

    a_update_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dhfk_pkg::ST_UPDATE) |-> (oi_reg <= 4'd11))
        else $error("pose update index out of range");

endmodule

/* hdl/dh_forward_kinematics_unit.sv */
// Each joint angle word passes through the back end as two sine and cosine evaluations,
// six transform products and 36 pose products on one shared 32x32 multiplier.
// The back end takes a new word only after it has finished the last one; the front queue holds two.
// A finished chain's pose waits in the back end until the previous result has been popped.
// Asynchronous active-low reset sets an identity pose, link index zero, link count six
// and clears all link parameters.
module dh_forward_kinematics_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] joint_angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] rot_00,
    output logic signed [31:0] rot_01,
    output logic signed [31:0] rot_02,
    output logic signed [31:0] rot_10,
    output logic signed [31:0] rot_11,
    output logic signed [31:0] rot_12,
    output logic signed [31:0] rot_20,
    output logic signed [31:0] rot_21,
    output logic signed [31:0] rot_22,
    output logic signed [31:0] trans_x,
    output logic signed [31:0] trans_y,
    output logic signed [31:0] trans_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic                 q_wr, q_full, q_valid, q_pop, out_valid;
    dhfk_pkg::link_item_t q_wdata, q_rdata;
    logic signed [31:0]   pose [0:11];

    assign cfg_ready = 1'b1;
    assign full = q_full;
    assign empty = !out_valid;

    dhfk_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .joint_angle (joint_angle),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_data      (q_wdata)
    );

    dhfk_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (q_wdata),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rdata)
    );

    dhfk_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (q_valid),
        .fifo_data  (q_rdata),
        .fifo_pop   (q_pop),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_pose   (pose)
    );

    assign rot_00 = pose[0];
    assign rot_01 = pose[1];
    assign rot_02 = pose[2];
    assign trans_x = pose[3];
    assign rot_10 = pose[4];
    assign rot_11 = pose[5];
    assign rot_12 = pose[6];
    assign trans_y = pose[7];
    assign rot_20 = pose[8];
    assign rot_21 = pose[9];
    assign rot_22 = pose[10];
    assign trans_z = pose[11];

endmodule
